>>> hw/rtl/c3sf_pkg.sv
// c3sf_pkg: constants, types and register codes of the 3x3 stream filter
// used by every file of the block; depends on nothing

package c3sf_pkg;

  localparam int PIX_BITS       = 8;
  localparam int COEF_BITS      = 8;
  localparam int KERNEL_SIZE    = 3;
  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MIN_DIM        = 3;

  localparam int WIDTH_REG_BITS  = 12;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int KROW_BITS       = 24;
  localparam int CFG_DATA_BITS   = 24;
  localparam int CFG_IDX_BITS    = 3;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
  localparam int PROD_BITS = PIX_BITS + COEF_BITS;

  typedef logic [PIX_BITS-1:0]                     pix_t;
  typedef logic [COEF_BITS-1:0]                    coef_t;
  typedef logic [COL_BITS-1:0]                     col_idx_t;
  typedef logic [ROW_BITS-1:0]                     row_idx_t;
  typedef logic [KERNEL_SIZE-1:0][PIX_BITS-1:0]    col_t;
  typedef logic [KERNEL_SIZE-1:0][COEF_BITS-1:0]   coef_col_t;
  typedef logic [KROW_BITS-1:0]                    krow_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT,
    CFG_KERNEL_TOP,
    CFG_KERNEL_MID,
    CFG_KERNEL_BOT
  } cfg_idx_t;

  // line store access of one cycle
  typedef struct packed {
    logic     rd_en;
    col_idx_t rd_addr;
    logic     wr_en;
    col_idx_t wr_addr;
    pix_t     wr_top;
    pix_t     wr_mid;
  } ls_req_t;

endpackage

>>> hw/rtl/c3sf_pix_if.sv
// c3sf_pix_if: input pixel channel, valid/ready with one pixel per word
// depends on c3sf_pkg

interface c3sf_pix_if;
  logic             valid;
  logic             ready;
  c3sf_pkg::pix_t   pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

>>> hw/rtl/c3sf_res_if.sv
// c3sf_res_if: result channel, valid/ready with filtered pixel and frame flag
// depends on c3sf_pkg

interface c3sf_res_if;
  logic             valid;
  logic             ready;
  c3sf_pkg::pix_t   pixel_out;
  logic             frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

>>> hw/rtl/c3sf_line_store.sv
// c3sf_line_store: the two row memories, one read and one write per cycle
// registered read data; depends on c3sf_pkg

module c3sf_line_store (
  input  logic              clk,
  input  c3sf_pkg::ls_req_t req,
  output c3sf_pkg::pix_t    rd_top,
  output c3sf_pkg::pix_t    rd_mid
);
  import c3sf_pkg::*;

  pix_t mem_a [MAX_WIDTH];
  pix_t mem_b [MAX_WIDTH];
  pix_t rd_top_r;
  pix_t rd_mid_r;

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_top_r <= mem_a[req.rd_addr];
      rd_mid_r <= mem_b[req.rd_addr];
    end
    if (req.wr_en) begin
      mem_a[req.wr_addr] <= req.wr_top;
      mem_b[req.wr_addr] <= req.wr_mid;
    end
  end

  assign rd_top = rd_top_r;
  assign rd_mid = rd_mid_r;

endmodule

>>> hw/rtl/c3sf_cell.sv
// c3sf_cell: one window column of three pixels, shifted from its neighbor or,
// at the head, from the new column, and weighted by its kernel column; depends on c3sf_pkg

module c3sf_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  c3sf_pkg::col_t      col_in,
  input  c3sf_pkg::coef_col_t coef,
  output c3sf_pkg::col_t      col_out,
  output c3sf_pkg::pix_t      psum
);
  import c3sf_pkg::*;

  col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  // low bits of signed coefficient times unsigned pixel
  always_comb begin
    logic [PROD_BITS-1:0] coef_ext;
    logic [PROD_BITS-1:0] pix_ext;
    logic [PROD_BITS-1:0] prod;
    pix_t                 acc;
    acc = '0;
    for (int u = 0; u < KERNEL_SIZE; u++) begin
      coef_ext = {{PIX_BITS{coef[u][COEF_BITS-1]}}, coef[u]};
      pix_ext  = {{COEF_BITS{1'b0}}, col_r[u]};
      prod     = coef_ext * pix_ext;
      acc      = acc + prod[PIX_BITS-1:0];
    end
    psum = acc;
  end

  assign col_out = col_r;

endmodule

>>> hw/rtl/conv3x3_stream_filter.sv
// conv3x3_stream_filter: streaming 3x3 convolution over two line stores
// depends on c3sf_pkg, c3sf_pix_if, c3sf_res_if, c3sf_line_store, c3sf_cell
//
//   channel   dir  word                    handshake
//   in_word   in   pixel_in[7:0]           valid & ready
//   out_word  out  pixel_out[7:0], frame_end  valid & ready
//   cfg_*     in   index[2:0], data[23:0]  cfg_we
//
// one pixel per clock sustained while out_word is not stalled; each result
// passes through the registered line store read, the window cells and the
// output register
// a stalled output freezes the whole pipeline and drops in_word.ready
// reset clears counters, window and valid bits; the line stores are not cleared

module conv3x3_stream_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  c3sf_pix_if.sink                             in_word,
  c3sf_res_if.source                           out_word,
  input  logic                                 cfg_we,
  input  logic [c3sf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [c3sf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import c3sf_pkg::*;

  logic [WIDTH_REG_BITS-1:0]  width_r;
  logic [HEIGHT_REG_BITS-1:0] height_r;
  krow_t                      kern_r [KERNEL_SIZE];

  col_idx_t col_r, col_nxt;
  row_idx_t row_r, row_nxt;

  logic     v1_r, emit1_r, last1_r;
  pix_t     px1_r;
  col_idx_t idx1_r;
  logic     v2_r, emit2_r, last2_r;

  logic     out_valid_r;
  pix_t     out_pixel_r;
  logic     out_end_r;

  logic [WIDTH_REG_BITS-1:0]  w_use;
  logic [HEIGHT_REG_BITS-1:0] h_use;
  col_idx_t                   w_last;
  row_idx_t                   h_last;
  logic                       adv, accept, row_end, frame_last, emit;

  ls_req_t   ls_req;
  pix_t      rd_top, rd_mid;
  col_t      col_new;
  col_t      cell_col [KERNEL_SIZE];
  pix_t      cell_psum [KERNEL_SIZE];
  coef_col_t cell_coef [KERNEL_SIZE];
  pix_t      out_pixel_nxt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_REG_BITS'(640);
      height_r <= HEIGHT_REG_BITS'(480);
      for (int u = 0; u < KERNEL_SIZE; u++) begin
        kern_r[u] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r   <= cfg_data[WIDTH_REG_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_r  <= cfg_data[HEIGHT_REG_BITS-1:0];
        CFG_KERNEL_TOP:   kern_r[0] <= cfg_data[KROW_BITS-1:0];
        CFG_KERNEL_MID:   kern_r[1] <= cfg_data[KROW_BITS-1:0];
        CFG_KERNEL_BOT:   kern_r[2] <= cfg_data[KROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    if (width_r < WIDTH_REG_BITS'(MIN_DIM)) begin
      w_use = WIDTH_REG_BITS'(MIN_DIM);
    end else if (width_r > WIDTH_REG_BITS'(MAX_WIDTH)) begin
      w_use = WIDTH_REG_BITS'(MAX_WIDTH);
    end else begin
      w_use = width_r;
    end
    if (height_r < HEIGHT_REG_BITS'(MIN_DIM)) begin
      h_use = HEIGHT_REG_BITS'(MIN_DIM);
    end else if (height_r > HEIGHT_REG_BITS'(MAX_HEIGHT)) begin
      h_use = HEIGHT_REG_BITS'(MAX_HEIGHT);
    end else begin
      h_use = height_r;
    end
  end

  assign w_last = COL_BITS'(w_use - WIDTH_REG_BITS'(1));
  assign h_last = ROW_BITS'(h_use - HEIGHT_REG_BITS'(1));

  assign adv     = !out_valid_r || out_word.ready;
  assign accept  = adv && in_word.valid;
  assign in_word.ready = adv;

  assign row_end    = (col_r >= w_last);
  assign frame_last = row_end && (row_r >= h_last);
  assign emit       = (row_r >= ROW_BITS'(2)) && (col_r >= COL_BITS'(2));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (frame_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_BITS'(1);
      end else begin
        col_nxt = col_r + COL_BITS'(1);
      end
    end
  end

  // control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (adv) begin
        v1_r        <= in_word.valid;
        v2_r        <= v1_r;
        out_valid_r <= v2_r && emit2_r;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      px1_r       <= in_word.pixel_in;
      idx1_r      <= col_r;
      emit1_r     <= emit;
      last1_r     <= frame_last;
      emit2_r     <= emit1_r;
      last2_r     <= last1_r;
      out_pixel_r <= out_pixel_nxt;
      out_end_r   <= last2_r;
    end
  end

  // line stores: read on accept, write back when the word enters the window
  always_comb begin
    ls_req.rd_en   = accept;
    ls_req.rd_addr = col_r;
    ls_req.wr_en   = adv && v1_r;
    ls_req.wr_addr = idx1_r;
    ls_req.wr_top  = rd_mid;
    ls_req.wr_mid  = px1_r;
  end

  c3sf_line_store u_line_store (
    .clk    (clk),
    .req    (ls_req),
    .rd_top (rd_top),
    .rd_mid (rd_mid)
  );

  assign col_new = {px1_r, rd_mid, rd_top};

  // window cells, column 0 oldest
  for (genvar k = 0; k < KERNEL_SIZE; k++) begin : g_cell
    for (genvar u = 0; u < KERNEL_SIZE; u++) begin : g_coef
      assign cell_coef[k][u] = kern_r[u][k*COEF_BITS +: COEF_BITS];
    end

    if (k == KERNEL_SIZE - 1) begin : g_head
      c3sf_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (adv && v1_r),
        .col_in   (col_new),
        .coef     (cell_coef[k]),
        .col_out  (cell_col[k]),
        .psum     (cell_psum[k])
      );
    end else begin : g_body
      c3sf_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (adv && v1_r),
        .col_in   (cell_col[k+1]),
        .coef     (cell_coef[k]),
        .col_out  (cell_col[k]),
        .psum     (cell_psum[k])
      );
    end
  end

  always_comb begin
    out_pixel_nxt = '0;
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      out_pixel_nxt = out_pixel_nxt + cell_psum[k];
    end
  end

  assign out_word.valid     = out_valid_r;
  assign out_word.pixel_out = out_pixel_r;
  assign out_word.frame_end = out_end_r;

endmodule
